// File: hw/rtl/sepd_pkg.sv
// shared types and constants of the scaled envelope curve player
package sepd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CFG_IW     = 3;
    localparam int CFG_DW     = 8;

    localparam logic [15:0] FULL_SCALE_PRODUCT = 16'd8192;
    localparam logic [15:0] MIN_SCALED_PRODUCT = 16'd32;
    localparam logic [4:0]  FRACTION_MASK      = 5'd31;
    localparam logic [7:0]  STEP_CEILING       = 8'd255;
    localparam logic [7:0]  BYTE_MAX           = 8'd255;
    localparam int          VOLUME_SHIFT       = 6;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_SPEED       = 3'd0,
        REG_SCALE       = 3'd1,
        REG_PITCH_MODE  = 3'd2,
        REG_POINT_COUNT = 3'd3,
        REG_LOOP_START  = 3'd4,
        REG_LOOP_END    = 3'd5,
        REG_INTERPOLATE = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_TICK,
        ST_READ,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [7:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

endpackage

// File: hw/rtl/scaled_envelope_curve_player_unit.sv
// top level of the scaled envelope curve player
//
// channel | direction | handshake          | fields
// s_      | in        | s_valid / s_ready  | kind, point_index, point_value, released
// m_      | out       | m_valid / m_ready  | level, running
// cfg_    | in        | cfg_wr_en          | cfg_index, cfg_data
//
// point write, idle tick and unused kind go straight to ST_DONE; start passes ST_START first
// a tick without a ramp division passes ST_TICK and ST_READ, only ST_TICK when it ends the curve;
// one with it also waits in ST_DIV on the 16-step serial divider (one quotient bit per cycle)
// one word is in flight at a time; a finished word waits in the output register
// synchronous active-low reset clears control state; the point table is not cleared
module scaled_envelope_curve_player_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [sepd_pkg::CFG_IW-1:0] cfg_index,
    input  logic [sepd_pkg::CFG_DW-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_kind,
    input  logic [5:0]                  s_point_index,
    input  logic [15:0]                 s_point_value,
    input  logic                        s_released,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_level,
    output logic                        m_running
);
    import sepd_pkg::*;

    state_t state_reg, state_next;

    logic [7:0]  speed_reg, scale_reg, loop_start_reg, loop_end_reg;
    logic [6:0]  point_count_reg;
    logic        pitch_mode_reg, interp_reg;

    logic [7:0]  position_reg, position_next;
    logic [7:0]  phase_acc_reg, phase_acc_next;
    logic [7:0]  countdown_reg, countdown_next;
    logic [7:0]  interval_reg, interval_next;
    logic [7:0]  phase_step_reg, phase_step_next;
    logic [15:0] ramp_acc_reg, ramp_acc_next;
    logic [15:0] ramp_step_reg, ramp_step_next;
    logic [15:0] level_reg, level_next;
    logic        unit_prec_reg, unit_prec_next;
    logic        sustain_reg, sustain_next;
    logic        playing_reg, playing_next;
    logic        rel_reg;
    logic        advance_reg, advance_next;
    logic [7:0]  prev_reg, prev_next;
    logic        oor_reg, oor_next;
    logic        neg_reg, neg_next;

    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_level_reg, m_level_next;
    logic        m_running_reg, m_running_next;

    logic              s_accept;
    logic              out_free;
    logic              tbl_wr_en;
    logic [PT_AW-1:0]  tbl_rd_addr;
    logic [15:0]       tbl_rd_data;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [15:0] product;
    logic [10:0] eff_raw;
    logic [7:0]  eff;
    logic [4:0]  frac;
    logic [8:0]  phase_sum;
    logic [8:0]  count9;
    logic [8:0]  pos_inc;
    logic        tick_stop;
    logic [7:0]  tick_pos;
    logic        tick_sustain;
    logic [15:0] target;
    logic        plain_load;
    logic        need_div;
    logic [15:0] signed_step;
    logic [15:0] ramp_sum;
    logic [15:0] ramp_div_sum;

    assign s_accept = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign tbl_wr_en = s_accept && (s_kind == KIND_WRITE) && (int'(s_point_index) < MAX_POINTS);

    sepd_ptab u_ptab (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (PT_AW'(s_point_index)),
        .wr_data (s_point_value),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    sepd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // start arithmetic
    always_comb begin
        product = {8'd0, speed_reg} * {8'd0, scale_reg};
        eff_raw = product[15:5];
        if (scale_reg == 8'd0) begin
            eff = speed_reg;
        end else if (eff_raw == 11'd0) begin
            eff = 8'd1;
        end else if (eff_raw > {3'b0, BYTE_MAX}) begin
            eff = BYTE_MAX;
        end else begin
            eff = eff_raw[7:0];
        end
        if (scale_reg == 8'd0 || product < MIN_SCALED_PRODUCT) begin
            frac = 5'd0;
        end else if (product >= FULL_SCALE_PRODUCT) begin
            frac = 5'd1;
        end else begin
            frac = product[4:0] & FRACTION_MASK;
        end
    end

    // tick position update
    always_comb begin
        phase_sum    = {1'b0, phase_acc_reg} + {1'b0, phase_step_reg};
        count9       = (point_count_reg == 7'd0) ? 9'(MAX_POINTS) : {2'b0, point_count_reg};
        pos_inc      = {1'b0, position_reg} + 9'd1;
        tick_stop    = 1'b0;
        tick_pos     = position_reg;
        tick_sustain = sustain_reg;
        if (phase_sum[8] && countdown_reg < 8'd2) begin
            if (pos_inc >= count9) begin
                if (position_reg != loop_end_reg) begin
                    tick_stop = 1'b1;
                end else begin
                    tick_pos = loop_start_reg;
                end
            end else begin
                tick_pos = pos_inc[7:0];
                if (sustain_reg) begin
                    if (rel_reg) begin
                        tick_sustain = 1'b0;
                        if ({1'b0, loop_end_reg} < count9) begin
                            tick_pos = loop_end_reg;
                        end
                    end else if (pos_inc[7:0] > loop_end_reg) begin
                        tick_pos = loop_start_reg;
                    end
                end
            end
        end
    end

    // ramp decision after the table read
    always_comb begin
        target       = oor_reg ? 16'd0 :
                       (unit_prec_reg ? tbl_rd_data : {tbl_rd_data[15-VOLUME_SHIFT:0],
                                                       VOLUME_SHIFT'(0)});
        plain_load   = !advance_reg || !interp_reg || interval_reg < 8'd2 || prev_reg == 8'd2;
        need_div     = !plain_load && prev_reg < 8'd3;
        signed_step  = neg_reg ? (16'd0 - div_rsp.quotient) : div_rsp.quotient;
        ramp_sum     = ramp_acc_reg + ramp_step_reg;
        ramp_div_sum = ramp_acc_reg + signed_step;
    end

    assign tbl_rd_addr = (state_reg == ST_TICK) ? PT_AW'(tick_pos) : '0;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_kind)
                        KIND_START: state_next = ST_START;
                        KIND_TICK:  state_next = playing_reg ? ST_TICK : ST_DONE;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_START: state_next = ST_DONE;
            ST_TICK:  state_next = tick_stop ? ST_DONE : ST_READ;
            ST_READ:  state_next = need_div ? ST_DIV : ST_DONE;
            ST_DIV:   state_next = div_rsp.done ? ST_DONE : ST_DIV;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        position_next   = position_reg;
        phase_acc_next  = phase_acc_reg;
        countdown_next  = countdown_reg;
        interval_next   = interval_reg;
        phase_step_next = phase_step_reg;
        ramp_acc_next   = ramp_acc_reg;
        ramp_step_next  = ramp_step_reg;
        level_next      = level_reg;
        unit_prec_next  = unit_prec_reg;
        sustain_next    = sustain_reg;
        playing_next    = playing_reg;
        advance_next    = advance_reg;
        prev_next       = prev_reg;
        oor_next        = oor_reg;
        neg_next        = neg_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_level_next    = m_level_reg;
        m_running_next  = m_running_reg;
        div_req         = '{start: 1'b0, dividend: '0, divisor: interval_reg};
        case (state_reg)
            ST_START: begin
                unit_prec_next  = pitch_mode_reg;
                level_next      = tbl_rd_data;
                ramp_acc_next   = pitch_mode_reg ? tbl_rd_data :
                                  {tbl_rd_data[15-VOLUME_SHIFT:0], VOLUME_SHIFT'(0)};
                interval_next   = eff;
                countdown_next  = (eff == BYTE_MAX) ? BYTE_MAX : eff + 8'd1;
                phase_step_next = STEP_CEILING - {3'b0, frac};
                position_next   = '0;
                phase_acc_next  = '0;
                ramp_step_next  = '0;
                sustain_next    = 1'b1;
                playing_next    = 1'b1;
            end
            ST_TICK: begin
                phase_acc_next = phase_sum[7:0];
                advance_next   = phase_sum[8];
                prev_next      = countdown_reg;
                if (phase_sum[8]) begin
                    countdown_next = (countdown_reg <= 8'd1) ? interval_reg :
                                     countdown_reg - 8'd1;
                end
                position_next = tick_pos;
                sustain_next  = tick_sustain;
                oor_next      = int'(tick_pos) >= MAX_POINTS;
                if (tick_stop) begin
                    playing_next = 1'b0;
                end
            end
            ST_READ: begin
                if (plain_load) begin
                    ramp_acc_next = target;
                    level_next    = unit_prec_reg ? target :
                                    {VOLUME_SHIFT'(0), target[15:VOLUME_SHIFT]};
                end else if (need_div) begin
                    neg_next         = target < ramp_acc_reg;
                    div_req.start    = 1'b1;
                    div_req.dividend = (target < ramp_acc_reg) ? ramp_acc_reg - target :
                                                                 target - ramp_acc_reg;
                end else begin
                    ramp_acc_next = ramp_sum;
                    level_next    = unit_prec_reg ? ramp_sum :
                                    {VOLUME_SHIFT'(0), ramp_sum[15:VOLUME_SHIFT]};
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    ramp_step_next = signed_step;
                    ramp_acc_next  = ramp_div_sum;
                    level_next     = unit_prec_reg ? ramp_div_sum :
                                     {VOLUME_SHIFT'(0), ramp_div_sum[15:VOLUME_SHIFT]};
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_level_next   = level_reg;
                    m_running_next = playing_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            speed_reg       <= 8'd1;
            scale_reg       <= 8'd0;
            pitch_mode_reg  <= 1'b0;
            point_count_reg <= 7'd0;
            loop_start_reg  <= 8'd0;
            loop_end_reg    <= 8'd255;
            interp_reg      <= 1'b0;
            position_reg    <= '0;
            phase_acc_reg   <= '0;
            countdown_reg   <= '0;
            interval_reg    <= '0;
            phase_step_reg  <= '0;
            ramp_acc_reg    <= '0;
            ramp_step_reg   <= '0;
            level_reg       <= '0;
            unit_prec_reg   <= 1'b1;
            sustain_reg     <= 1'b0;
            playing_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            position_reg   <= position_next;
            phase_acc_reg  <= phase_acc_next;
            countdown_reg  <= countdown_next;
            interval_reg   <= interval_next;
            phase_step_reg <= phase_step_next;
            ramp_acc_reg   <= ramp_acc_next;
            ramp_step_reg  <= ramp_step_next;
            level_reg      <= level_next;
            unit_prec_reg  <= unit_prec_next;
            sustain_reg    <= sustain_next;
            playing_reg    <= playing_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SPEED:       speed_reg       <= cfg_data;
                    REG_SCALE:       scale_reg       <= cfg_data;
                    REG_PITCH_MODE:  pitch_mode_reg  <= cfg_data[0];
                    REG_POINT_COUNT: point_count_reg <= cfg_data[6:0];
                    REG_LOOP_START:  loop_start_reg  <= cfg_data;
                    REG_LOOP_END:    loop_end_reg    <= cfg_data;
                    REG_INTERPOLATE: interp_reg      <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        if (s_accept) begin
            rel_reg <= s_released;
        end
        advance_reg   <= advance_next;
        prev_reg      <= prev_next;
        oor_reg       <= oor_next;
        neg_reg       <= neg_next;
        m_level_reg   <= m_level_next;
        m_running_reg <= m_running_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_level   = m_level_reg;
    assign m_running = m_running_reg;

endmodule

// File: hw/rtl/sepd_ptab.sv
// curve point table memory with registered read
module sepd_ptab (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [sepd_pkg::PT_AW-1:0] wr_addr,
    input  logic [15:0]              wr_data,
    input  logic [sepd_pkg::PT_AW-1:0] rd_addr,
    output logic [15:0]              rd_data
);
    import sepd_pkg::*;

    logic [15:0] mem [MAX_POINTS];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/sepd_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module sepd_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  sepd_pkg::div_req_t req,
    output sepd_pkg::div_rsp_t rsp
);
    import sepd_pkg::*;

    logic [7:0]  rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [8:0]  trial;
    logic [8:0]  trial_sub;
    logic        ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[15]};
        trial_sub = trial - {1'b0, req.divisor};
        ge        = trial >= {1'b0, req.divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = 4'd15;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? trial_sub[7:0] : trial[7:0];
            quo_next = {quo_reg[14:0], ge};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
